[hdl/cdq_pkg.sv]
// Shared types and constants for the circular deque core.
`default_nettype none

package cdq_pkg;

  localparam int WORD_W        = 32;
  localparam int DEPTH_DEFAULT = 64;

  typedef enum logic [1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_REAR  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_REAR   = 2'd3
  } cdq_mode_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } cdq_status_t;

  // At most one of these is set in a cycle.
  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
  } cdq_ctl_t;

endpackage

`default_nettype wire

[hdl/cdq_cell.sv]
// One storage cell of the deque chain: a word, its valid bit and neighbor moves.
`default_nettype none

module cdq_cell import cdq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cdq_ctl_t          ctl,
  input  wire logic [WORD_W-1:0] push_word,
  input  wire logic [WORD_W-1:0] left_word,
  input  wire logic              left_valid,
  input  wire logic [WORD_W-1:0] right_word,
  input  wire logic              right_valid,
  output logic      [WORD_W-1:0] word,
  output logic                   valid,
  output logic                   valid_next,
  output logic      [WORD_W-1:0] tap
);

  logic [WORD_W-1:0] word_next;

  // Front ops shift the whole chain; rear ops touch only the boundary cell.
  always_comb begin
    word_next  = word;
    valid_next = valid;
    priority if (ctl.push_front) begin
      word_next  = left_word;
      valid_next = left_valid;
    end else if (ctl.pop_front) begin
      word_next  = right_word;
      valid_next = right_valid;
    end else if (ctl.push_rear) begin
      if (!valid && left_valid) begin
        word_next  = push_word;
        valid_next = 1'b1;
      end
    end else if (ctl.pop_rear) begin
      if (valid && !right_valid) begin
        valid_next = 1'b0;
      end
    end
  end

  // Rear cell presents its word; all others give zero so the top can OR them.
  assign tap = (valid && !right_valid) ? word : '0;

  always_ff @(posedge clk) begin
    word <= word_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

`default_nettype wire

[hdl/circular_deque_core.sv]
// Double-ended queue built as a chain of shifting storage cells.
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   in      | in_valid, in_stall, mode, push_word  | into core
//   out     | out_valid, out_stall, pop_word,      | out of core
//           | status, is_empty, is_full            |
//
// One item per cycle while in_stall is low: every operation updates all cells at
// the edge that accepts it (front ops shift the chain, rear ops hit the boundary
// cell), and the result lands in the output register on that same edge.
// Reset clears every cell's valid bit, giving an empty deque; words are not reset.
// in_stall is high only while a result sits in the output register and out_stall
// holds it there.
`default_nettype none

module circular_deque_core import cdq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        mode,
  input  wire logic [WORD_W-1:0] push_word,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [WORD_W-1:0] pop_word,
  output logic      [1:0]        status,
  output logic                   is_empty,
  output logic                   is_full
);

  logic [WORD_W-1:0] cell_word [DEPTH];
  logic [WORD_W-1:0] cell_tap  [DEPTH];
  logic [DEPTH-1:0]  cell_valid;
  logic [DEPTH-1:0]  cell_valid_next;

  cdq_ctl_t          ctl;
  cdq_status_t       st;
  logic              accept;
  logic              cur_empty;
  logic              cur_full;
  logic [WORD_W-1:0] rear_word;
  logic [WORD_W-1:0] pop_data;

  assign in_stall  = out_valid & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign cur_empty = ~cell_valid[0];
  assign cur_full  = cell_valid[DEPTH-1];

  always_comb begin
    ctl      = '0;
    st       = ST_DONE;
    pop_data = '0;
    unique case (cdq_mode_t'(mode))
      MODE_PUSH_FRONT: begin
        if (cur_full) st = ST_OVERFLOW;
        else          ctl.push_front = accept;
      end
      MODE_PUSH_REAR: begin
        if (cur_full) st = ST_OVERFLOW;
        else          ctl.push_rear = accept;
      end
      MODE_POP_FRONT: begin
        if (cur_empty) begin
          st = ST_UNDERFLOW;
        end else begin
          ctl.pop_front = accept;
          pop_data      = cell_word[0];
        end
      end
      MODE_POP_REAR: begin
        if (cur_empty) begin
          st = ST_UNDERFLOW;
        end else begin
          ctl.pop_rear = accept;
          pop_data     = rear_word;
        end
      end
      default: st = ST_DONE;
    endcase
  end

  // Only the rear cell drives a nonzero tap.
  always_comb begin
    rear_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_word = rear_word | cell_tap[i];
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_W-1:0] left_word;
    logic              left_valid;
    logic [WORD_W-1:0] right_word;
    logic              right_valid;

    if (g == 0) begin : g_first
      assign left_word  = push_word;
      assign left_valid = 1'b1;
    end else begin : g_mid_left
      assign left_word  = cell_word[g-1];
      assign left_valid = cell_valid[g-1];
    end

    if (g == DEPTH-1) begin : g_last
      assign right_word  = '0;
      assign right_valid = 1'b0;
    end else begin : g_mid_right
      assign right_word  = cell_word[g+1];
      assign right_valid = cell_valid[g+1];
    end

    cdq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .push_word   (push_word),
      .left_word   (left_word),
      .left_valid  (left_valid),
      .right_word  (right_word),
      .right_valid (right_valid),
      .word        (cell_word[g]),
      .valid       (cell_valid[g]),
      .valid_next  (cell_valid_next[g]),
      .tap         (cell_tap[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pop_word <= pop_data;
      status   <= st;
      is_empty <= ~cell_valid_next[0];
      is_full  <= cell_valid_next[DEPTH-1];
    end
  end

endmodule

`default_nettype wire

[dv/tb.sv]
// Testbench for circular_deque_core: directed table, then random deque traffic with a scoreboard.
`default_nettype none

module tb;
  import cdq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = DEPTH_DEFAULT;
  localparam int RANDOM_OPS  = 1830;
  localparam int CALM_TAIL   = 200;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    cdq_status_t       st;
    logic              empty;
    logic              full;
  } deque_result_t;

  typedef struct packed {
    cdq_mode_t         op;
    logic [WORD_W-1:0] w;
    logic              typed;
    deque_result_t     want;
  } op_row_t;

  localparam deque_result_t NO_WANT = '{32'h0, ST_DONE, 1'b0, 1'b0};

  // typed rows carry their own result; the rest go through the predictor
  localparam op_row_t OP_TABLE [0:21] = '{
    '{MODE_POP_FRONT,  32'h0000_0000, 1'b1, '{32'h0, ST_UNDERFLOW, 1'b1, 1'b0}},
    '{MODE_POP_REAR,   32'hFFFF_FFFF, 1'b1, '{32'h0, ST_UNDERFLOW, 1'b1, 1'b0}},
    '{MODE_PUSH_FRONT, 32'h0000_0000, 1'b1, '{32'h0, ST_DONE,      1'b0, 1'b0}},
    '{MODE_POP_REAR,   32'h1234_5678, 1'b1, '{32'h0, ST_DONE,      1'b1, 1'b0}},
    '{MODE_PUSH_REAR,  32'hFFFF_FFFF, 1'b1, '{32'h0, ST_DONE,      1'b0, 1'b0}},
    // front push wraps the head below zero; then empty out at the wrap point
    '{MODE_PUSH_FRONT, 32'h5A5A_5A5A, 1'b0, NO_WANT},
    '{MODE_POP_REAR,   32'h0000_0000, 1'b0, NO_WANT},
    '{MODE_POP_FRONT,  32'h0000_0000, 1'b0, NO_WANT},
    '{MODE_POP_FRONT,  32'hFFFF_FFFF, 1'b1, '{32'h0, ST_UNDERFLOW, 1'b1, 1'b0}},
    '{MODE_PUSH_REAR,  32'h8000_0000, 1'b0, NO_WANT},
    '{MODE_PUSH_REAR,  32'h0000_0001, 1'b0, NO_WANT},
    '{MODE_PUSH_REAR,  32'h7FFF_FFFF, 1'b0, NO_WANT},
    '{MODE_PUSH_FRONT, 32'hA5A5_A5A5, 1'b0, NO_WANT},
    '{MODE_PUSH_FRONT, 32'hFFFF_FFFE, 1'b0, NO_WANT},
    '{MODE_POP_FRONT,  32'h0000_0000, 1'b0, NO_WANT},
    '{MODE_POP_REAR,   32'h0000_0000, 1'b0, NO_WANT},
    '{MODE_POP_FRONT,  32'h0000_0000, 1'b0, NO_WANT},
    '{MODE_POP_FRONT,  32'h0000_0000, 1'b0, NO_WANT},
    '{MODE_POP_REAR,   32'h0000_0000, 1'b0, NO_WANT},
    '{MODE_POP_REAR,   32'h0000_0000, 1'b1, '{32'h0, ST_UNDERFLOW, 1'b1, 1'b0}},
    '{MODE_PUSH_FRONT, 32'hDEAD_BEEF, 1'b0, NO_WANT},
    '{MODE_POP_FRONT,  32'h0000_0000, 1'b0, NO_WANT}
  };

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        mode;
  logic [WORD_W-1:0] push_word;
  logic              out_valid;
  logic              out_stall;
  logic [WORD_W-1:0] pop_word;
  logic [1:0]        status;
  logic              is_empty;
  logic              is_full;

  circular_deque_core #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .push_word (push_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pop_word  (pop_word),
    .status    (status),
    .is_empty  (is_empty),
    .is_full   (is_full)
  );

  // deque mirror
  logic [WORD_W-1:0] ring_word [DEPTH];
  int                front_idx;
  int                rear_idx;
  bit                ring_vacant;

  deque_result_t pending_results [$];
  int            mismatch_count;
  bit            tx_idle_en;
  bit            rx_idle_en;
  bit            hold_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL circular_deque_core");
    $finish;
  end

  task automatic flag_mismatch(input string what, input logic [WORD_W-1:0] got,
                               input logic [WORD_W-1:0] want);
    mismatch_count++;
    $display("%0t: %s mismatch: got %h, want %h", $time, what, got, want);
  endtask

  function automatic bit ring_is_full();
    return !ring_vacant && front_idx == (rear_idx + 1) % DEPTH;
  endfunction

  function automatic deque_result_t apply_deque_op(cdq_mode_t op, logic [WORD_W-1:0] w);
    deque_result_t r;
    r.word = '0;
    r.st   = ST_DONE;
    if (op == MODE_PUSH_FRONT || op == MODE_PUSH_REAR) begin
      if (ring_is_full()) begin
        r.st = ST_OVERFLOW;
      end else if (ring_vacant) begin
        // first word always lands at position zero
        front_idx    = 0;
        rear_idx     = 0;
        ring_vacant  = 1'b0;
        ring_word[0] = w;
      end else if (op == MODE_PUSH_FRONT) begin
        front_idx            = (front_idx + DEPTH - 1) % DEPTH;
        ring_word[front_idx] = w;
      end else begin
        rear_idx            = (rear_idx + 1) % DEPTH;
        ring_word[rear_idx] = w;
      end
    end else if (ring_vacant) begin
      r.st = ST_UNDERFLOW;
    end else if (op == MODE_POP_FRONT) begin
      r.word = ring_word[front_idx];
      if (front_idx == rear_idx) ring_vacant = 1'b1;
      else front_idx = (front_idx + 1) % DEPTH;
    end else begin
      r.word = ring_word[rear_idx];
      if (front_idx == rear_idx) ring_vacant = 1'b1;
      else rear_idx = (rear_idx + DEPTH - 1) % DEPTH;
    end
    r.empty = ring_vacant;
    r.full  = ring_is_full();
    return r;
  endfunction

  // offer one item, hold it until accepted, then maybe leave a gap
  task automatic send_item(input cdq_mode_t op, input logic [WORD_W-1:0] w,
                           input logic typed, input deque_result_t want);
    deque_result_t predicted;
    int            gap;
    @(negedge clk);
    in_valid  = 1'b1;
    mode      = op;
    push_word = w;
    do @(posedge clk); while (!(in_valid && !in_stall));
    predicted = apply_deque_op(op, w);
    pending_results.push_back(typed ? want : predicted);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk);
      in_valid  = 1'b0;
      mode      = 2'($urandom_range(0, 3));
      push_word = $urandom();
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // receiver: random stall bursts, plus one long hold on request
  initial begin : rx_side
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_stall  = 1'b1;
        stall_left = $urandom_range(0, 17);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  initial begin : result_check
    deque_result_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("unexpected item", pop_word, '0);
        end else begin
          want = pending_results.pop_front();
          if (pop_word !== want.word) flag_mismatch("pop_word", pop_word, want.word);
          if (status !== want.st)     flag_mismatch("status", 32'(status), 32'(want.st));
          if (is_empty !== want.empty)
            flag_mismatch("is_empty", 32'(is_empty), 32'(want.empty));
          if (is_full !== want.full)
            flag_mismatch("is_full", 32'(is_full), 32'(want.full));
        end
      end
    end
  end

  initial begin : stimulus
    int                sent;
    int                phase_len;
    int                push_pct;
    bit                held;
    bit                paused;
    cdq_mode_t         op;
    logic [WORD_W-1:0] w;
    rst            = 1'b1;
    in_valid       = 1'b0;
    mode           = MODE_PUSH_FRONT;
    push_word      = '0;
    hold_req       = 1'b0;
    tx_idle_en     = 1'b1;
    rx_idle_en     = 1'b1;
    mismatch_count = 0;
    front_idx      = 0;
    rear_idx       = 0;
    ring_vacant    = 1'b1;
    sent           = 0;
    held           = 1'b0;
    paused         = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (OP_TABLE[i])
      send_item(OP_TABLE[i].op, OP_TABLE[i].w, OP_TABLE[i].typed, OP_TABLE[i].want);

    // phases with a fill, drain or even bias, so full and empty are both reached often
    while (sent < RANDOM_OPS) begin
      phase_len = $urandom_range(10, 140);
      case ($urandom_range(0, 4))
        0:       push_pct = 92;
        1:       push_pct = 8;
        2:       push_pct = 50;
        3:       push_pct = 70;
        default: push_pct = 30;
      endcase
      if (sent >= RANDOM_OPS - CALM_TAIL) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end else begin
        tx_idle_en = $urandom_range(0, 2) != 0;
        rx_idle_en = $urandom_range(0, 2) != 0;
      end
      if (!held && sent > 400) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && sent > 900) begin
        paused = 1'b1;
        // the last item was already taken; stop offering it while draining
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      for (int k = 0; k < phase_len && sent < RANDOM_OPS; k++) begin
        if ($urandom_range(0, 99) < push_pct)
          op = $urandom_range(0, 1) ? MODE_PUSH_REAR : MODE_PUSH_FRONT;
        else
          op = $urandom_range(0, 1) ? MODE_POP_REAR : MODE_POP_FRONT;
        case ($urandom_range(0, 7))
          0:       w = '0;
          1:       w = '1;
          2:       w = 32'h1 << $urandom_range(0, 31);
          3:       w = ~(32'h1 << $urandom_range(0, 31));
          default: w = $urandom();
        endcase
        send_item(op, w, 1'b0, NO_WANT);
        sent++;
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS circular_deque_core");
    end else begin
      $display("FAIL circular_deque_core");
    end
    $finish;
  end

endmodule

`default_nettype wire
